>>> rtl/f2i_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package f2i_pkg;
    typedef enum logic [3:0] {
        TT_S8 = 4'd0, TT_U8 = 4'd1, TT_S16 = 4'd2, TT_U16 = 4'd3,
        TT_S32 = 4'd4, TT_U32 = 4'd5, TT_S64L = 4'd6, TT_S64 = 4'd7,
        TT_U64 = 4'd8, TT_DBL = 4'd9
    } target_t;

    typedef struct packed {
        logic [31:0] external_word;
        logic        last_item;
    } f2i_in_t;

    typedef struct packed {
        logic [63:0] value_bits;
        logic        range_error;
        logic        last_result;
    } f2i_out_t;
endpackage
`default_nettype wire

>>> rtl/f2i_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface f2i_stream_if #(parameter int Width = 1);
    logic             valid;
    logic             ready;
    logic [Width-1:0] payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> rtl/float_to_integer_convert_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel    Dir  Payload
// in_ch      in   external_word[31:0], last_item
// out_ch     out  value_bits[63:0], range_error, last_result
// cfg        in   cfg_we, cfg_wdata[3:0] (target_type)
//
// Three register stages: decode/shift, limit compare, select/saturate.
// One request enters per cycle while the pipe is not stalled.
// Stalls: a stage advances when it is empty or the next one moves, so a
// held output freezes the pipe without loss. Reset empties all stages and
// sets target_type to s32.
module float_to_integer_convert_core
    import f2i_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        cfg_we,
    input  wire [3:0]  cfg_wdata,
    f2i_stream_if.sink   in_ch,
    f2i_stream_if.source out_ch
);
    logic [3:0] tt_reg;
    logic       v1_reg, v2_reg, v3_reg;
    logic       adv1, adv2, adv3;

    // stage 1 outputs
    logic        nan1_reg, neg1_reg, big1_reg, frac1_reg, last1_reg;
    logic [63:0] mag1_reg, dbl1_reg;
    // stage 2 outputs
    logic        neg2_reg, nan2_reg, over2_reg, nz2_reg, last2_reg, sgn2_reg, dbl2_reg;
    logic [63:0] mag2_reg, lim2_reg, dv2_reg;
    logic [3:0]  tt2_reg;
    // stage 3
    f2i_out_t    out_reg;

    assign adv3 = !v3_reg || out_ch.ready;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign in_ch.ready  = adv1;
    assign out_ch.valid = v3_reg;
    assign out_ch.payload = out_reg;

    f2i_in_t din;
    assign din = in_ch.payload;

    // Stage 1: split the word, align the magnitude, widen to double.
    logic [7:0]  e;
    logic [22:0] m;
    logic [63:0] full, mag_n, dbl_n;
    logic        frac_n, big_n;
    logic [4:0]  p;
    logic        found;
    logic [7:0]  sh;
    always_comb
    begin
        e = din.external_word[30:23];
        m = din.external_word[22:0];
        full = {40'd0, 1'b1, m};
        mag_n = '0;
        frac_n = 1'b0;
        big_n = 1'b0;
        sh = 8'd0;
        if (e < 8'd127)
        begin
            frac_n = (e != 8'd0) || (m != 23'd0);
        end
        else if (e <= 8'd150)
        begin
            sh = 8'd150 - e;
            mag_n = full >> sh[4:0];
            frac_n = (full & ((64'd1 << sh[4:0]) - 64'd1)) != 64'd0;
        end
        else if (e < 8'd191)
        begin
            sh = e - 8'd150;
            mag_n = full << sh[5:0];
        end
        else
        begin
            big_n = 1'b1;
        end
        // priority encode for subnormal normalization
        p = 5'd0;
        found = 1'b0;
        for (int i = 22; i >= 0; i--)
        begin
            if (!found && m[i])
            begin
                p = 5'(i);
                found = 1'b1;
            end
        end
        dbl_n = {din.external_word[31], 63'd0};
        // NaN: keep payload in place and force the quiet bit
        if (e == 8'hFF)
            dbl_n = {din.external_word[31], 11'h7FF, (m != 23'd0), m[21:0], 29'd0};
        else if (e == 8'd0)
        begin
            if (m != 23'd0)
                dbl_n = {din.external_word[31], 11'(p) + 11'd874,
                         (52'(m) << (6'd52 - 6'(p))) & ~(52'd1 << 52)};
        end
        else
            dbl_n = {din.external_word[31], 11'(e) + 11'd896, m, 29'd0};
    end

    // Stage 2: pick limit and compare.
    logic [6:0]  bits;
    logic        sgn;
    logic [63:0] lim_n;
    always_comb
    begin
        sgn = 1'b0;
        bits = 7'd32;
        case (tt_reg)
            TT_S8:   begin bits = 7'd8;  sgn = 1'b1; end
            TT_U8:   bits = 7'd8;
            TT_S16:  begin bits = 7'd16; sgn = 1'b1; end
            TT_U16:  bits = 7'd16;
            TT_S32:  begin bits = 7'd32; sgn = 1'b1; end
            TT_U32:  bits = 7'd32;
            TT_S64L, TT_S64: begin bits = 7'd64; sgn = 1'b1; end
            TT_U64:  bits = 7'd64;
            default: bits = 7'd32;
        endcase
        if (!sgn)
            lim_n = (bits == 7'd64) ? '1 : ((64'd1 << bits[5:0]) - 64'd1);
        else if (neg1_reg)
            lim_n = 64'd1 << (bits[5:0] - 6'd1);
        else
            lim_n = (64'd1 << (bits[5:0] - 6'd1)) - 64'd1;
    end

    // Stage 3: saturate and select.
    f2i_out_t res;
    always_comb
    begin
        res.last_result = last2_reg;
        res.range_error = 1'b0;
        res.value_bits = '0;
        if (dbl2_reg)
            res.value_bits = dv2_reg;
        else if (tt2_reg > TT_DBL)
            res.range_error = 1'b1;
        else if (nan2_reg)
            res.range_error = 1'b1;
        else if (!sgn2_reg && neg2_reg)
            res.range_error = nz2_reg;
        else
        begin
            res.range_error = over2_reg;
            if (neg2_reg)
                res.value_bits = over2_reg ? (64'd0 - lim2_reg) : (64'd0 - mag2_reg);
            else
                res.value_bits = over2_reg ? lim2_reg : mag2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tt_reg <= TT_S32;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                tt_reg <= cfg_wdata;
            if (adv1)
                v1_reg <= in_ch.valid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
        end
    end

    // payload: hold on stall, no reset
    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            nan1_reg  <= (e == 8'hFF) && (m != 23'd0);
            neg1_reg  <= din.external_word[31];
            big1_reg  <= big_n;
            frac1_reg <= frac_n;
            mag1_reg  <= mag_n;
            dbl1_reg  <= dbl_n;
            last1_reg <= din.last_item;
        end
        if (adv2)
        begin
            neg2_reg  <= neg1_reg;
            nan2_reg  <= nan1_reg;
            over2_reg <= big1_reg || (mag1_reg > lim_n) || (mag1_reg == lim_n && frac1_reg);
            nz2_reg   <= (mag1_reg != 64'd0) || frac1_reg || big1_reg;
            mag2_reg  <= mag1_reg;
            lim2_reg  <= lim_n;
            dv2_reg   <= dbl1_reg;
            sgn2_reg  <= sgn;
            dbl2_reg  <= (tt_reg == TT_DBL);
            tt2_reg   <= tt_reg;
            last2_reg <= last1_reg;
        end
        if (adv3)
            out_reg <= res;
    end

    // a stalled result must stay put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.payload))
        else $error("result changed under stall");
    // double path never flags
    assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && dbl2_reg |-> !res.range_error)
        else $error("double path flagged");
    // unsigned negative result is zero
    assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && !dbl2_reg && !sgn2_reg && neg2_reg |-> res.value_bits == 64'd0)
        else $error("unsigned negative not zero");
endmodule
`default_nettype wire
